// ----- hdl/recent_id_blackout_filter_top_assert.svh -----
// Assertion macros for the recent ID blackout filter checker
`ifndef RECENT_ID_BLACKOUT_FILTER_TOP_ASSERT_SVH
`define RECENT_ID_BLACKOUT_FILTER_TOP_ASSERT_SVH

// check a consequent in the same cycle as its antecedent
`define RIBF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check a consequent in the cycle after its antecedent
`define RIBF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/ribf_pkg.sv -----
// Shared types and constants for the recent ID blackout filter
package ribf_pkg;

    localparam int unsigned RIBF_TABLE_DEPTH = 16;
    localparam int unsigned ID_W             = 16;
    localparam int unsigned TIME_W           = 48;
    localparam int unsigned PERIOD_W         = 24;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd80000;

    typedef struct packed {
        logic [ID_W-1:0]   request_id;
        logic [TIME_W-1:0] now_us;
    } t_req;

    typedef struct packed {
        logic allowed;
        logic not_recorded;
    } t_rsp;

    typedef struct packed {
        logic              vld;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] now;
        logic              hit;
        logic              free_found;
    } t_tok;

    typedef struct packed {
        logic              fire;
        logic              store;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] expiry;
    } t_commit;

endpackage

// ----- hdl/ribf_cell.sv -----
// One table cell: holds an entry, checks the passing request token, hands it on
module ribf_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ribf_pkg::t_tok    i_tok,
    input  ribf_pkg::t_commit i_commit,
    output ribf_pkg::t_tok    o_tok
);
    import ribf_pkg::*;

    logic              r_valid;
    logic              n_valid;
    logic              r_cand;
    logic              n_cand;
    logic [ID_W-1:0]   r_id;
    logic [TIME_W-1:0] r_expiry;
    t_tok              r_tok;
    t_tok              n_tok;
    logic              w_live;
    logic              w_write;

    always_comb begin
        w_live  = r_valid && (r_expiry > i_tok.now);
        w_write = i_commit.fire && i_commit.store && r_cand;

        n_valid = r_valid;
        if (w_write) begin
            n_valid = 1'b1;
        end else if (i_tok.vld && !w_live) begin
            n_valid = 1'b0;
        end

        n_cand = r_cand;
        if (i_commit.fire) begin
            n_cand = 1'b0;
        end else if (i_tok.vld && !w_live && !i_tok.free_found) begin
            n_cand = 1'b1;
        end

        n_tok = i_tok;
        if (i_tok.vld) begin
            if (w_live && (r_id == i_tok.id)) begin
                n_tok.hit = 1'b1;
            end
            if (!w_live) begin
                n_tok.free_found = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok.id         <= n_tok.id;
        r_tok.now        <= n_tok.now;
        r_tok.hit        <= n_tok.hit;
        r_tok.free_found <= n_tok.free_found;
        if (w_write) begin
            r_id     <= i_commit.id;
            r_expiry <= i_commit.expiry;
        end
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_cand    <= 1'b0;
            r_tok.vld <= 1'b0;
        end else begin
            r_valid   <= n_valid;
            r_cand    <= n_cand;
            r_tok.vld <= n_tok.vld;
        end
    end

    assign o_tok = r_tok;

endmodule

// ----- hdl/recent_id_blackout_filter_top.sv -----
// Top level of the recent ID blackout filter: request token runs down a chain of table cells
// A request passes the head register, each cell register and the result register in turn.
// Only one request is in flight: start is taken only while busy is low, as the token walks the
// cell chain one cell per cycle; busy stays high until the result strobe.
// The receiver cannot stall; each result shows on o_rsp for one cycle with o_strobe.
// Reset (synchronous, active low) empties the table and sets the period to 80000 us.
module recent_id_blackout_filter_top #(
    parameter int unsigned TABLE_DEPTH = ribf_pkg::RIBF_TABLE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  ribf_pkg::t_req                i_req,
    output logic                          o_strobe,
    output ribf_pkg::t_rsp                o_rsp,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ribf_pkg::PERIOD_W-1:0] i_cfg_data
);
    import ribf_pkg::*;

    logic [PERIOD_W-1:0] r_period;
    logic                r_busy;
    logic                n_busy;
    t_tok                r_head;
    t_tok                n_head;
    logic [TIME_W-1:0]   r_exp;
    logic [TIME_W-1:0]   n_exp;
    logic                r_strobe;
    logic                n_strobe;
    t_rsp                r_rsp;
    t_rsp                n_rsp;
    t_commit             r_commit;
    t_commit             n_commit;
    logic [TIME_W:0]     w_sum;
    logic                w_accept;
    t_tok                w_tok [TABLE_DEPTH+1];

    assign w_tok[0] = r_head;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        ribf_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_tok    (w_tok[g]),
            .i_commit (r_commit),
            .o_tok    (w_tok[g+1])
        );
    end

    always_comb begin
        w_accept = start && !r_busy;
        w_sum    = {1'b0, i_req.now_us} + {{(TIME_W + 1 - PERIOD_W){1'b0}}, r_period};

        n_head            = r_head;
        n_head.vld        = w_accept;
        n_head.id         = i_req.request_id;
        n_head.now        = i_req.now_us;
        n_head.hit        = 1'b0;
        n_head.free_found = 1'b0;

        n_exp = r_exp;
        if (w_accept) begin
            n_exp = w_sum[TIME_W] ? {TIME_W{1'b1}} : w_sum[TIME_W-1:0];
        end

        n_busy = r_busy;
        if (w_tok[TABLE_DEPTH].vld) begin
            n_busy = 1'b0;
        end else if (w_accept) begin
            n_busy = 1'b1;
        end
    end

    always_comb begin
        n_strobe           = w_tok[TABLE_DEPTH].vld;
        n_rsp.allowed      = !w_tok[TABLE_DEPTH].hit;
        n_rsp.not_recorded = !w_tok[TABLE_DEPTH].hit && !w_tok[TABLE_DEPTH].free_found;
        n_commit.fire      = w_tok[TABLE_DEPTH].vld;
        n_commit.store     = !w_tok[TABLE_DEPTH].hit && w_tok[TABLE_DEPTH].free_found;
        n_commit.id        = w_tok[TABLE_DEPTH].id;
        n_commit.expiry    = r_exp;
    end

    always_ff @(posedge i_clk) begin
        r_head.id         <= n_head.id;
        r_head.now        <= n_head.now;
        r_head.hit        <= n_head.hit;
        r_head.free_found <= n_head.free_found;
        r_exp             <= n_exp;
        r_rsp             <= n_rsp;
        r_commit.store    <= n_commit.store;
        r_commit.id       <= n_commit.id;
        r_commit.expiry   <= n_commit.expiry;
        if (!i_rst_n) begin
            r_period      <= PERIOD_RESET;
            r_busy        <= 1'b0;
            r_head.vld    <= 1'b0;
            r_strobe      <= 1'b0;
            r_commit.fire <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_period <= i_cfg_data;
            end
            r_busy        <= n_busy;
            r_head.vld    <= n_head.vld;
            r_strobe      <= n_strobe;
            r_commit.fire <= n_commit.fire;
        end
    end

    assign busy        = r_busy;
    assign o_strobe    = r_strobe;
    assign o_rsp       = r_rsp;
    assign o_cfg_ready = 1'b1;

endmodule

// ----- hdl/ribf_chk.sv -----
// Port-level assertion checker for the recent ID blackout filter, bound to the top level
`include "recent_id_blackout_filter_top_assert.svh"

module ribf_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_strobe,
    input ribf_pkg::t_rsp o_rsp
);
    import ribf_pkg::*;

    `RIBF_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "busy low after start transfer")
    `RIBF_ASSERT_SAME(a_strobe_not_busy, o_strobe, !busy, "result strobe while busy")
    `RIBF_ASSERT_SAME(a_refused_not_flagged, o_strobe && !o_rsp.allowed,
                      !o_rsp.not_recorded, "refused request flagged not recorded")
    `RIBF_ASSERT_NEXT(a_strobe_single, o_strobe, !o_strobe, "result strobe held two cycles")

endmodule

bind recent_id_blackout_filter_top ribf_chk u_ribf_chk (.*);

// ----- test/tb_top.sv -----
// Self-checking testbench for the recent ID blackout filter: directed table, then random phases
`timescale 1ns / 100ps

module tb_top;
    import ribf_pkg::*;

    localparam int unsigned TABLE_DEPTH = RIBF_TABLE_DEPTH;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam logic [TIME_W-1:0] T_MAX = '1;
    localparam t_rsp RSP_ALLOW  = '{allowed: 1'b1, not_recorded: 1'b0};
    localparam t_rsp RSP_REFUSE = '{allowed: 1'b0, not_recorded: 1'b0};
    localparam t_rsp RSP_FULL   = '{allowed: 1'b1, not_recorded: 1'b1};
    localparam t_rsp RSP_NONE   = '0;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind           kind;
        logic [ID_W-1:0]     request_id;
        logic [TIME_W-1:0]   now_us;
        logic [PERIOD_W-1:0] period;
        logic                typed;
        t_rsp                rsp;
    } t_row;

    localparam int unsigned N_ROWS = 27;

    t_row directed_rows [N_ROWS] = '{
        '{ROW_REQ, 16'h0000, 48'd0,          24'd0, 1'b1, RSP_ALLOW},
        '{ROW_REQ, 16'h0000, 48'd0,          24'd0, 1'b1, RSP_REFUSE},
        '{ROW_REQ, 16'hFFFF, 48'd79999,      24'd0, 1'b0, RSP_NONE},
        '{ROW_REQ, 16'h0000, 48'd80000,      24'd0, 1'b1, RSP_ALLOW},
        '{ROW_REQ, 16'hFFFF, 48'd80000,      24'd0, 1'b1, RSP_REFUSE},
        '{ROW_REQ, 16'h0001, 48'd100000,     24'd0, 1'b0, RSP_NONE},
        '{ROW_REQ, 16'h0002, 48'd100000,     24'd0, 1'b0, RSP_NONE},
        '{ROW_REQ, 16'h0003, 48'd100000,     24'd0, 1'b0, RSP_NONE},
        '{ROW_REQ, 16'h0004, 48'd100000,     24'd0, 1'b0, RSP_NONE},
        '{ROW_REQ, 16'h0005, 48'd100000,     24'd0, 1'b0, RSP_NONE},
        '{ROW_REQ, 16'h0006, 48'd100000,     24'd0, 1'b0, RSP_NONE},
        '{ROW_REQ, 16'h0007, 48'd100000,     24'd0, 1'b0, RSP_NONE},
        '{ROW_REQ, 16'h0008, 48'd100000,     24'd0, 1'b0, RSP_NONE},
        '{ROW_REQ, 16'h0009, 48'd100000,     24'd0, 1'b0, RSP_NONE},
        '{ROW_REQ, 16'h000A, 48'd100000,     24'd0, 1'b0, RSP_NONE},
        '{ROW_REQ, 16'h000B, 48'd100000,     24'd0, 1'b0, RSP_NONE},
        '{ROW_REQ, 16'h000C, 48'd100000,     24'd0, 1'b0, RSP_NONE},
        '{ROW_REQ, 16'h000D, 48'd100000,     24'd0, 1'b0, RSP_NONE},
        '{ROW_REQ, 16'h000E, 48'd100000,     24'd0, 1'b0, RSP_NONE},
        '{ROW_REQ, 16'h1234, 48'd100000,     24'd0, 1'b1, RSP_FULL},
        '{ROW_CFG, 16'h0000, 48'd0,          24'd0, 1'b0, RSP_NONE},
        '{ROW_REQ, 16'hAAAA, T_MAX,          24'd0, 1'b0, RSP_NONE},
        '{ROW_REQ, 16'hAAAA, T_MAX,          24'd0, 1'b1, RSP_ALLOW},
        '{ROW_CFG, 16'h0000, 48'd0,   24'hFFFFFF, 1'b0, RSP_NONE},
        '{ROW_REQ, 16'h5555, T_MAX - 48'd1,  24'd0, 1'b0, RSP_NONE},
        '{ROW_REQ, 16'h5555, 48'd10,         24'd0, 1'b1, RSP_REFUSE},
        '{ROW_REQ, 16'h5555, T_MAX,          24'd0, 1'b0, RSP_NONE}
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    t_req                i_req;
    logic                o_strobe;
    t_rsp                o_rsp;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [PERIOD_W-1:0] i_cfg_data;

    logic [PERIOD_W-1:0] period_q;
    logic                held_valid  [TABLE_DEPTH];
    logic [ID_W-1:0]     held_id     [TABLE_DEPTH];
    logic [TIME_W-1:0]   held_expiry [TABLE_DEPTH];
    t_rsp                expected_rsps [$];
    int unsigned         error_count;
    int unsigned         cycle_count;
    int unsigned         burst_left;

    recent_id_blackout_filter_top #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_strobe   (o_strobe),
        .o_rsp      (o_rsp),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_strobe) begin
            if (expected_rsps.size() == 0) begin
                $error("result transfer with no request outstanding");
                error_count++;
            end else begin
                want = expected_rsps.pop_front();
                if (o_rsp.allowed !== want.allowed) begin
                    $error("allowed: expected %0b, got %0b", want.allowed, o_rsp.allowed);
                    error_count++;
                end
                if (o_rsp.not_recorded !== want.not_recorded) begin
                    $error("not_recorded: expected %0b, got %0b",
                           want.not_recorded, o_rsp.not_recorded);
                    error_count++;
                end
            end
        end
    end

    function automatic t_rsp predict_admit(input logic [ID_W-1:0] id,
                                           input logic [TIME_W-1:0] now);
        logic            hit;
        int              free_cell;
        logic [TIME_W:0] sum;
        t_rsp            rsp;
        hit = 1'b0;
        free_cell = -1;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            if (held_valid[k] && held_expiry[k] <= now)
                held_valid[k] = 1'b0;
            if (held_valid[k]) begin
                if (held_id[k] == id)
                    hit = 1'b1;
            end else if (free_cell < 0) begin
                free_cell = k;
            end
        end
        if (hit)
            return RSP_REFUSE;
        sum = {1'b0, now} + {{(TIME_W - PERIOD_W + 1){1'b0}}, period_q};
        if (free_cell >= 0) begin
            held_valid[free_cell]  = 1'b1;
            held_id[free_cell]     = id;
            held_expiry[free_cell] = sum[TIME_W] ? T_MAX : sum[TIME_W-1:0];
            rsp = RSP_ALLOW;
        end else begin
            rsp = RSP_FULL;
        end
        return rsp;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (burst_left != 0) begin
            burst_left--;
            return 0;
        end
        if (r < 4)
            burst_left = $urandom_range(20, 40);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(20, 60);
    endfunction

    task automatic issue_request(input t_req req, input logic use_typed, input t_rsp typed_rsp);
        int unsigned gap;
        t_rsp        predicted;
        gap = pick_gap();
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req <= req;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        predicted = predict_admit(req.request_id, req.now_us);
        expected_rsps.push_back(use_typed ? typed_rsp : predicted);
        @(negedge i_clk);
    endtask

    task automatic write_period(input logic [PERIOD_W-1:0] value);
        start <= 1'b0;
        while (expected_rsps.size() != 0) @(negedge i_clk);
        repeat (TABLE_DEPTH + 4) @(negedge i_clk);
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        period_q = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        t_req                req;
        logic [PERIOD_W-1:0] per;
        logic [TIME_W-1:0]   base;
        logic [63:0]         wide;
        int unsigned         pool;
        int unsigned         step_max;
        int unsigned         r;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        error_count = 0;
        cycle_count = 0;
        burst_left  = 0;
        period_q    = PERIOD_RESET;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            held_valid[k]  = 1'b0;
            held_id[k]     = '0;
            held_expiry[k] = '0;
        end
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < N_ROWS; n++) begin
            if (directed_rows[n].kind == ROW_CFG) begin
                write_period(directed_rows[n].period);
            end else begin
                req.request_id = directed_rows[n].request_id;
                req.now_us     = directed_rows[n].now_us;
                issue_request(req, directed_rows[n].typed, directed_rows[n].rsp);
            end
        end

        base = '0;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: per = 24'd40;
                1: per = 24'd1;
                2: per = PERIOD_W'($urandom_range(2, 3000));
                3: per = PERIOD_RESET;
                4: per = 24'hFFFFFF;
                default: per = 24'd0;
            endcase
            write_period(per);
            pool     = $urandom_range(6, 40);
            step_max = per / 6 + 1;
            for (int n = 0; n < 75; n++) begin
                r = $urandom_range(0, 99);
                req.request_id = (r < 8) ? ID_W'($urandom) : ID_W'($urandom_range(0, pool - 1));
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    wide = {$urandom, $urandom};
                    req.now_us = TIME_W'(wide % ({16'd0, base} + 64'd1));
                end else begin
                    if (r < 6)
                        base = base + {8'd0, 8'($urandom), 32'($urandom)};
                    else
                        base = base + TIME_W'($urandom_range(0, step_max));
                    req.now_us = base;
                end
                issue_request(req, 1'b0, RSP_NONE);
            end
        end

        start <= 1'b0;
        while (expected_rsps.size() != 0) @(posedge i_clk);
        repeat (TABLE_DEPTH + 4) @(posedge i_clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- recent_id_blackout_filter_top.f -----
+incdir+hdl
hdl/ribf_pkg.sv
hdl/ribf_cell.sv
hdl/recent_id_blackout_filter_top.sv
hdl/ribf_chk.sv
test/tb_top.sv
